### hw/rtl/ntft_pkg.sv
// shared types and constants for the nearest timestamp frame table
// no dependencies; imported by ntft_ctrl, ntft_dp and the top level
package ntft_pkg;

	localparam int STAMP_W  = 63;
	localparam int HANDLE_W = 48;
	localparam int KEEP_W   = 8;
	localparam int ENTRY_W  = STAMP_W + HANDLE_W;

	// keep count after reset
	localparam logic [KEEP_W-1:0] KEEP_RESET = 8'd100;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_REPLY
	} ntft_state_t;

	// controller to datapath
	typedef struct packed {
		logic insert;      // append frame from input beat
		logic load_query;  // latch query stamp, rewind scan pointer
		logic issue;       // read one slot and advance scan pointer
		logic reply;       // capture result and raise done
	} ntft_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;       // no frames held
		logic last_issue;  // current issue reads the newest frame
		logic pipe_busy;   // compare pipeline still holds entries
	} ntft_status_t;

endpackage

### hw/rtl/ntft_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ntft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/ntft_ctrl.sv
// controller state machine of the nearest timestamp frame table
// depends on ntft_pkg
module ntft_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  operation,
	input  ntft_pkg::ntft_status_t status,
	output ntft_pkg::ntft_cmd_t    cmd,
	output logic                  busy
);

	import ntft_pkg::*;

	ntft_state_t state_q;
	ntft_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && operation == OP_QUERY) begin
					state_nxt = status.empty ? ST_REPLY : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.last_issue) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_nxt = ST_REPLY;
				end
			end
			ST_REPLY: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy           = 1'b0;
				cmd.insert     = start && operation == OP_INSERT;
				cmd.load_query = start && operation == OP_QUERY;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_REPLY: begin
				cmd.reply = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/ntft_dp.sv
// datapath: ring pointers, frame ram, distance pipeline and result registers
// depends on ntft_pkg and ntft_ram
module ntft_dp #(
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ntft_pkg::ntft_cmd_t               cmd,
	output ntft_pkg::ntft_status_t            status,
	input  logic [ntft_pkg::STAMP_W-1:0]      stamp,
	input  logic [ntft_pkg::HANDLE_W-1:0]     handle,
	input  logic                             keep_count_we,
	input  logic [ntft_pkg::KEEP_W-1:0]       keep_count,
	output logic                             done,
	output logic                             found,
	output logic [ntft_pkg::HANDLE_W-1:0]     match_handle,
	output logic [ntft_pkg::STAMP_W-1:0]      distance
);

	import ntft_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int EW = (CW > KEEP_W) ? CW : KEEP_W;

	// ring state
	logic [KEEP_W-1:0] keep_q;
	logic [AW-1:0]     oldest_q;
	logic [CW-1:0]     held_q;

	// effective keep count, clamped to 1..DEPTH
	logic [EW-1:0] keep_ext;
	logic [CW-1:0] keep_eff;

	always_comb begin
		keep_ext = EW'(keep_q);
		if (keep_q == '0) begin
			keep_eff = CW'(1);
		end else if (keep_ext > EW'(DEPTH)) begin
			keep_eff = CW'(DEPTH);
		end else begin
			keep_eff = keep_ext[CW-1:0];
		end
	end

	// insert: write slot is oldest + held whether or not frames get dropped
	logic [SW-1:0] wr_sum;
	logic [AW-1:0] wr_slot;
	logic          drop_en;
	logic [CW-1:0] drop_n;
	logic [SW-1:0] old_sum;
	logic [AW-1:0] oldest_nxt;

	always_comb begin
		wr_sum  = SW'(oldest_q) + SW'(held_q);
		wr_slot = (wr_sum >= SW'(DEPTH)) ? AW'(wr_sum - SW'(DEPTH)) : wr_sum[AW-1:0];
		drop_en = held_q >= keep_eff;
		drop_n  = held_q - keep_eff + CW'(1);
		old_sum = SW'(oldest_q) + SW'(drop_n);
		oldest_nxt = (old_sum >= SW'(DEPTH)) ? AW'(old_sum - SW'(DEPTH))
		                                     : old_sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q   <= KEEP_RESET;
			oldest_q <= '0;
			held_q   <= '0;
		end else begin
			if (keep_count_we) begin
				keep_q <= keep_count;
			end
			if (cmd.insert) begin
				if (drop_en) begin
					oldest_q <= oldest_nxt;
					held_q   <= keep_eff;
				end else begin
					held_q <= held_q + CW'(1);
				end
			end
		end
	end

	// scan pointer
	logic [AW-1:0]       rd_slot_q;
	logic [CW-1:0]       rd_cnt_q;
	logic [STAMP_W-1:0]  qstamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_slot_q <= '0;
			rd_cnt_q  <= '0;
		end else if (cmd.load_query) begin
			rd_slot_q <= oldest_q;
			rd_cnt_q  <= '0;
		end else if (cmd.issue) begin
			rd_slot_q <= (rd_slot_q == AW'(DEPTH - 1)) ? '0 : rd_slot_q + AW'(1);
			rd_cnt_q  <= rd_cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qstamp_q <= stamp;
		end
	end

	// frame ram, stamp in the upper bits
	logic [ENTRY_W-1:0] rd_entry;

	ntft_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.insert),
		.waddr(wr_slot),
		.wdata({stamp, handle}),
		.re   (cmd.issue),
		.raddr(rd_slot_q),
		.rdata(rd_entry)
	);

	// stage 1 is the ram output, stage 2 the absolute difference
	logic                vld_s1;
	logic                first_s1;
	logic                vld_s2;
	logic                first_s2;
	logic [STAMP_W-1:0]  diff_s2;
	logic [HANDLE_W-1:0] handle_s2;
	logic [STAMP_W-1:0]  ent_stamp;

	assign ent_stamp = rd_entry[ENTRY_W-1:HANDLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			vld_s1   <= cmd.issue;
			first_s1 <= cmd.issue && rd_cnt_q == '0;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			diff_s2   <= (ent_stamp >= qstamp_q) ? ent_stamp - qstamp_q
			                                     : qstamp_q - ent_stamp;
			handle_s2 <= rd_entry[HANDLE_W-1:0];
		end
	end

	// running best, strict compare keeps the oldest on ties
	logic [STAMP_W-1:0]  best_dist_q;
	logic [HANDLE_W-1:0] best_handle_q;

	always_ff @(posedge clk) begin
		if (vld_s2 && (first_s2 || diff_s2 < best_dist_q)) begin
			best_dist_q   <= diff_s2;
			best_handle_q <= handle_s2;
		end
	end

	// result registers
	logic                done_q;
	logic                found_q;
	logic [HANDLE_W-1:0] match_q;
	logic [STAMP_W-1:0]  dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.reply;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			found_q <= held_q != '0;
			match_q <= (held_q != '0) ? best_handle_q : '0;
			dist_q  <= (held_q != '0) ? best_dist_q : '0;
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign match_handle = match_q;
	assign distance     = dist_q;

	assign status.empty      = held_q == '0;
	assign status.last_issue = cmd.issue && (rd_cnt_q + CW'(1) == held_q);
	assign status.pipe_busy  = vld_s1 || vld_s2;

endmodule

### hw/rtl/nearest_timestamp_frame_table.sv
// top level of the nearest timestamp frame table
// depends on ntft_pkg, ntft_ctrl, ntft_dp (which holds ntft_ram)

// Keeps a ring of up to DEPTH frames (63-bit nanosecond stamp, 48-bit handle)
// and answers nearest-in-time queries. A beat is taken when start is high and
// busy is low; operation selects insert or query. An insert raises no busy and
// produces no result: when the ring already holds the keep count (keep_count
// clamped to 1..DEPTH), the oldest frames are dropped first. A query walks the
// held frames oldest to newest through the single read port of the frame ram,
// one slot per cycle, so busy stays high through the scan, the drain of the
// read and compare stages and the reply state, and done pulses in the cycle
// after the reply state with found, match_handle and distance; the oldest frame
// wins a tie. A query on an empty ring skips the scan and answers with found
// low and zero fields. Results are shown for exactly one cycle on done and
// cannot be stalled, so the receiver must capture them then. keep_count is
// written with keep_count_we and should change only while the block is idle.
module nearest_timestamp_frame_table #(
	parameter int DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command beat
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [ntft_pkg::STAMP_W-1:0]  stamp,
	input  logic [ntft_pkg::HANDLE_W-1:0] handle,
	// keep count register
	input  logic                          keep_count_we,
	input  logic [ntft_pkg::KEEP_W-1:0]   keep_count,
	// result beat
	output logic                          done,
	output logic                          found,
	output logic [ntft_pkg::HANDLE_W-1:0] match_handle,
	output logic [ntft_pkg::STAMP_W-1:0]  distance
);

	import ntft_pkg::*;

	ntft_cmd_t    cmd;
	ntft_status_t status;

	// sequencer: idle, scan, pipeline drain, reply
	ntft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// ring pointers, frame ram, distance compare, result registers
	ntft_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.stamp        (stamp),
		.handle       (handle),
		.keep_count_we(keep_count_we),
		.keep_count   (keep_count),
		.done         (done),
		.found        (found),
		.match_handle (match_handle),
		.distance     (distance)
	);

endmodule

### verif/tb_nearest_timestamp_frame_table.sv
// self-checking testbench for nearest_timestamp_frame_table
// depends on ntft_pkg and the block rtl; carries its own frame ring predictor
// directed beats cover extremes, ties and keep count corner cases; random traffic covers the rest
module tb_nearest_timestamp_frame_table;
	import ntft_pkg::*;

	localparam int DEPTH        = 128;
	localparam int STALL_LIMIT  = 2000;  // well above the longest correct quiet stretch, a full-ring query
	localparam int SETTLE_COUNT = 8;     // idle margin before a keep count write
	localparam int TAIL_COUNT   = 20;    // catch stray strobes after the last answer
	localparam logic [STAMP_W-1:0] STAMP_MAX  = '1;
	localparam logic [HANDLE_W-1:0] HANDLE_MAX = '1;

	// one query answer as seen on the result ports
	typedef struct packed {
		logic                found;
		logic [HANDLE_W-1:0] match_handle;
		logic [STAMP_W-1:0]  distance;
	} answer_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                operation;
	logic [STAMP_W-1:0]  stamp;
	logic [HANDLE_W-1:0] handle;
	logic                keep_count_we;
	logic [KEEP_W-1:0]   keep_count;
	logic                done;
	logic                found;
	logic [HANDLE_W-1:0] match_handle;
	logic [STAMP_W-1:0]  distance;

	nearest_timestamp_frame_table #(.DEPTH(DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.stamp        (stamp),
		.handle       (handle),
		.keep_count_we(keep_count_we),
		.keep_count   (keep_count),
		.done         (done),
		.found        (found),
		.match_handle (match_handle),
		.distance     (distance)
	);

	// predictor state: a mirror of the frame ring
	logic [STAMP_W-1:0]  ring_stamp [DEPTH];
	logic [HANDLE_W-1:0] ring_handle [DEPTH];
	int                  ring_oldest;
	int                  ring_held;
	logic [KEEP_W-1:0]   keep_setting;
	logic [STAMP_W-1:0]  camera_clock;  // running frame time for well-formed traffic

	answer_t pending_answers[$];  // answers owed by the block, oldest first

	int fault_count;
	int inserts_sent;
	int queries_sent;
	int empty_queries;
	int answers_seen;
	int keep_writes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// keep count as the block applies it: zero acts as one, above DEPTH saturates
	function automatic int kept_limit();
		int lim;
		lim = int'(keep_setting);
		if (lim == 0) lim = 1;
		if (lim > DEPTH) lim = DEPTH;
		return lim;
	endfunction

	// advance the mirror by one accepted beat; queries queue their answer
	function automatic void track_beat(logic op, logic [STAMP_W-1:0] st,
			logic [HANDLE_W-1:0] hd);
		int lim;
		int drop;
		int slot;
		int i;
		logic [STAMP_W-1:0] s;
		logic [STAMP_W-1:0] d;
		answer_t ans;
		if (op == OP_INSERT) begin
			lim = kept_limit();
			// a lowered keep count drops several oldest frames at once
			if (ring_held >= lim) begin
				drop = ring_held - lim + 1;
				ring_oldest = (ring_oldest + drop) % DEPTH;
				ring_held -= drop;
			end
			slot = (ring_oldest + ring_held) % DEPTH;
			ring_stamp[slot] = st;
			ring_handle[slot] = hd;
			ring_held++;
			inserts_sent++;
		end else begin
			ans = '0;
			if (ring_held == 0) empty_queries++;
			// oldest to newest, strict less-than keeps the oldest on a tie
			for (i = 0; i < ring_held; i++) begin
				slot = (ring_oldest + i) % DEPTH;
				s = ring_stamp[slot];
				d = (s >= st) ? s - st : st - s;
				if (i == 0 || d < ans.distance) begin
					ans.distance = d;
					ans.match_handle = ring_handle[slot];
				end
				ans.found = 1'b1;
			end
			pending_answers = {pending_answers, ans};
			queries_sent++;
		end
	endfunction

	function automatic logic [STAMP_W-1:0] any_stamp();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[STAMP_W-1:0];
	endfunction

	function automatic logic [HANDLE_W-1:0] any_handle();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[HANDLE_W-1:0];
	endfunction

	function automatic logic [STAMP_W-1:0] held_stamp();
		return ring_stamp[(ring_oldest + $urandom_range(0, ring_held - 1)) % DEPTH];
	endfunction

	// insert stamps: mostly a camera-like frame clock, plus tiny and wild values
	function automatic logic [STAMP_W-1:0] pick_frame_stamp();
		case ($urandom_range(0, 9))
			0, 1: return STAMP_W'($urandom_range(0, 63));
			2, 3: return any_stamp();
			default: begin
				camera_clock += STAMP_W'(33_333_333 + $urandom_range(0, 2_000_000));
				return camera_clock;
			end
		endcase
	endfunction

	// query stamps: near a held frame, between two held frames, tiny, or anywhere
	function automatic logic [STAMP_W-1:0] pick_query_stamp();
		logic [STAMP_W-1:0] s;
		logic [STAMP_W-1:0] off;
		logic [STAMP_W:0]   sum;
		int                 mode;
		mode = $urandom_range(0, 9);
		if (ring_held == 0 || mode >= 8) return any_stamp();
		if (mode >= 6) return STAMP_W'($urandom_range(0, 63));
		if (mode >= 4) begin
			// midpoints of even gaps land exactly on a tie
			sum = {1'b0, held_stamp()} + {1'b0, held_stamp()};
			return sum[STAMP_W:1];
		end
		s = held_stamp();
		off = STAMP_W'($urandom_range(0, 1000));
		if ($urandom_range(0, 1)) s = (s > STAMP_MAX - off) ? STAMP_MAX : s + off;
		else s = (s < off) ? '0 : s - off;
		return s;
	endfunction

	// present one beat and hold it until the block takes it
	task automatic send_beat(input logic op, input logic [STAMP_W-1:0] st,
			input logic [HANDLE_W-1:0] hd);
		@(negedge clk);
		start = 1'b1;
		operation = op;
		stamp = st;
		handle = hd;
		do @(posedge clk); while (busy !== 1'b0);
		track_beat(op, st, hd);
	endtask

	task automatic idle_burst(input int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending, let every owed answer arrive, then idle for extra cycles
	task automatic settle_idle(input int extra);
		@(negedge clk);
		start = 1'b0;
		while (pending_answers.size() != 0 || busy !== 1'b0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_keep(input logic [KEEP_W-1:0] value);
		settle_idle(SETTLE_COUNT);
		@(negedge clk);
		keep_count_we = 1'b1;
		keep_count = value;
		@(negedge clk);
		keep_count_we = 1'b0;
		keep_setting = value;
		keep_writes++;
	endtask

	// query before anything is stored: found low, fields zero, handle ignored
	task automatic test_empty_table();
		send_beat(OP_QUERY, '0, HANDLE_MAX);
		send_beat(OP_QUERY, STAMP_MAX, '0);
	endtask

	// frames at both ends of the stamp range and both handle extremes
	task automatic test_field_extremes();
		send_beat(OP_INSERT, '0, HANDLE_MAX);
		send_beat(OP_INSERT, STAMP_MAX, '0);
		send_beat(OP_QUERY, '0, '0);
		send_beat(OP_QUERY, STAMP_MAX, HANDLE_MAX);
		send_beat(OP_QUERY, 63'h4000_0000_0000_0000, any_handle());
	endtask

	// equal distances and duplicate stamps must pick the oldest frame
	task automatic test_nearest_and_ties();
		send_beat(OP_INSERT, 63'd1000, 48'h0000_0000_0a0a);
		send_beat(OP_INSERT, 63'd2000, 48'h0000_0000_0b0b);
		send_beat(OP_QUERY, 63'd1500, any_handle());
		send_beat(OP_INSERT, 63'd1000, 48'h0000_0000_0c0c);
		send_beat(OP_QUERY, 63'd1000, any_handle());
		send_beat(OP_QUERY, 63'd1999, any_handle());
	endtask

	// keep count of one, and zero which acts as one; also the widest distance
	task automatic test_keep_one_and_zero();
		write_keep(8'd1);
		send_beat(OP_INSERT, STAMP_MAX, 48'h5555_5555_5555);
		send_beat(OP_QUERY, '0, '0);
		send_beat(OP_INSERT, 63'd5, 48'haaaa_aaaa_aaaa);
		send_beat(OP_QUERY, 63'd6, any_handle());
		write_keep(8'd0);
		send_beat(OP_INSERT, 63'd7, 48'h1234_5678_9abc);
		send_beat(OP_QUERY, 63'd7, any_handle());
	endtask

	// lowering the keep count: frames stay until the next insert trims them
	task automatic test_keep_lowered();
		write_keep(8'd128);
		for (int i = 0; i < 5; i++) send_beat(OP_INSERT, 63'(100 * i), any_handle());
		write_keep(8'd2);
		send_beat(OP_QUERY, 63'd250, any_handle());
		send_beat(OP_INSERT, 63'd450, any_handle());
		send_beat(OP_QUERY, 63'd250, any_handle());
	endtask

	// random mix of inserts and queries under one keep setting
	task automatic test_random_traffic(input logic [KEEP_W-1:0] keep, input int beats,
			input int insert_pct, input bit with_gaps);
		write_keep(keep);
		repeat (beats) begin
			if ($urandom_range(1, 100) <= insert_pct)
				send_beat(OP_INSERT, pick_frame_stamp(), any_handle());
			else
				send_beat(OP_QUERY, pick_query_stamp(), any_handle());
			if (with_gaps && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 16));
		end
	endtask

	// every done strobe is one answer; compare it with the oldest one owed
	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n && done !== 1'b0) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				$error("result with no query outstanding");
				fault_count++;
			end else begin
				want = pending_answers.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					fault_count++;
				end
				if (match_handle !== want.match_handle) begin
					$error("match_handle: expected %h, got %h", want.match_handle,
						match_handle);
					fault_count++;
				end
				if (distance !== want.distance) begin
					$error("distance: expected %h, got %h", want.distance, distance);
					fault_count++;
				end
			end
		end
	end

	// ends the run if neither side moves for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || keep_count_we) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_INSERT;
		stamp = '0;
		handle = '0;
		keep_count_we = 1'b0;
		keep_count = KEEP_RESET;
		fault_count = 0;
		inserts_sent = 0;
		queries_sent = 0;
		empty_queries = 0;
		answers_seen = 0;
		keep_writes = 0;
		ring_oldest = 0;
		ring_held = 0;
		keep_setting = KEEP_RESET;
		camera_clock = 63'($urandom);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, first under the reset keep count
		test_empty_table();
		test_field_extremes();
		test_nearest_and_ties();
		test_keep_one_and_zero();
		test_keep_lowered();

		// 255 saturates to the full ring; insert-heavy so the ring wraps
		test_random_traffic(8'd255, 170, 85, 1'b1);
		test_random_traffic(8'd1, 50, 60, 1'b1);
		test_random_traffic(8'd0, 40, 60, 1'b1);
		test_random_traffic(8'd2, 50, 60, 1'b1);
		test_random_traffic(8'd17, 80, 65, 1'b1);
		test_random_traffic(8'($urandom_range(1, 255)), 80, 65, 1'b1);
		test_random_traffic(8'd128, 90, 75, 1'b1);
		// last stretch back at the reset value, beats sent back to back
		test_random_traffic(KEEP_RESET, 90, 65, 1'b0);

		settle_idle(TAIL_COUNT);

		$display("covered %0d frame inserts and %0d queries (%0d on an empty table)",
			inserts_sent, queries_sent, empty_queries);
		$display("checked %0d answers across %0d keep count writes, 0 through 255",
			answers_seen, keep_writes);
		if (fault_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/ntft_pkg.sv
hw/rtl/ntft_ram.sv
hw/rtl/ntft_ctrl.sv
hw/rtl/ntft_dp.sv
hw/rtl/nearest_timestamp_frame_table.sv
verif/tb_nearest_timestamp_frame_table.sv
